// File: hw/rtl/toy_cpu_execute_unit_assert.svh
// assertion macros shared by the execute unit rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef TOY_CPU_EXECUTE_UNIT_ASSERT_SVH
`define TOY_CPU_EXECUTE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TCPU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent implies consequent in the following cycle
`define TCPU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/tcpu_pkg.sv
// types and constants of the toy cpu execute unit
// no dependencies
package tcpu_pkg;

    localparam int DATA_W        = 16;
    localparam int DEF_MEM_BYTES = 32768;
    localparam int DEF_NUM_REGS  = 16;
    localparam int REGIDX_W      = 5;

    localparam logic [DATA_W-1:0] IP_STEP = 16'd4;

    // mov with a nonzero source index up to this value stores a register to memory
    localparam logic [3:0] MOV_STORE_MAX = 4'd4;

    typedef enum logic [3:0] {
        OP_HALT = 4'd0,
        OP_MOV  = 4'd1,
        OP_ADD  = 4'd2,
        OP_SUB  = 4'd3,
        OP_MUL  = 4'd4,
        OP_DIV  = 4'd5,
        OP_AND  = 4'd6,
        OP_OR   = 4'd7,
        OP_NOT  = 4'd8,
        OP_CMP  = 4'd9,
        OP_JMP  = 4'd10,
        OP_IN   = 4'd11,
        OP_OUT  = 4'd12
    } op_t;

    // jump conditions carried in the source index field
    localparam logic [3:0] JC_ALWAYS = 4'd0;
    localparam logic [3:0] JC_EQ     = 4'd1;
    localparam logic [3:0] JC_GT     = 4'd2;
    localparam logic [3:0] JC_LT     = 4'd3;

    localparam logic [1:0] FLAG_EQ = 2'b00;
    localparam logic [1:0] FLAG_GT = 2'b01;
    localparam logic [1:0] FLAG_LT = 2'b11;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REG,
        ST_MEM,
        ST_DIV
    } state_t;

endpackage

// File: hw/rtl/toy_cpu_execute_unit.sv
// top level of the toy cpu execute unit
// depends on tcpu_pkg, tcpu_ram, tcpu_div and toy_cpu_execute_unit_assert.svh

// Executes one already fetched instruction per request and returns one result
// (next ip, compare flag, halt, out value, divide-by-zero). Registers live in
// two copies of a small synchronous ram, data memory in two byte-wide banks
// (even and odd addresses) so a big-endian word at any byte address is read or
// written in one access. After reset a clearing pass writes zero to every
// memory row and register, during which in_ready stays low. A request then
// reads its registers; when its operand is a memory word, one more synchronous
// read follows the register read, and a divide by a nonzero divisor then runs
// in the bit-serial divider. The result sits in an output register; if it has
// not been taken, the next instruction waits at its final step. MEM_BYTES must
// be a power of two; NUM_REGS may be 9 to 16, higher indices read as zero and
// ignore writes.

`include "toy_cpu_execute_unit_assert.svh"

module toy_cpu_execute_unit #(
    parameter int MEM_BYTES = tcpu_pkg::DEF_MEM_BYTES,
    parameter int NUM_REGS  = tcpu_pkg::DEF_NUM_REGS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [3:0]                         cmd,
    input  logic [3:0]                         dst_idx,
    input  logic [3:0]                         src_idx,
    input  logic signed [tcpu_pkg::DATA_W-1:0] imm,
    input  logic signed [tcpu_pkg::DATA_W-1:0] in_value,
    // result channel
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic signed [tcpu_pkg::DATA_W-1:0] next_ip,
    output logic signed [1:0]                  cmp_flag,
    output logic                               halted,
    output logic                               out_valid,
    output logic signed [tcpu_pkg::DATA_W-1:0] out_value,
    output logic                               div_by_zero
);
    import tcpu_pkg::*;

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int ROWS   = MEM_BYTES / 2;
    localparam int ROW_W  = ADDR_W - 1;
    localparam int REG_W  = $clog2(NUM_REGS);

    // control state
    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  clr_reg, clr_next;
    logic [DATA_W-1:0] ip_reg;
    logic [1:0]        flag_reg;
    logic              res_valid_reg;

    // latched request
    op_t               op_reg;
    logic [3:0]        r1_reg;
    logic [3:0]        r2_reg;
    logic [DATA_W-1:0] imm_reg;
    logic [DATA_W-1:0] inv_reg;

    // result payload
    logic [DATA_W-1:0] next_ip_reg;
    logic [1:0]        cmp_flag_reg;
    logic              halted_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              div_by_zero_reg;

    // register file ports (two copies, one read port each)
    logic [REG_W-1:0]  rf_raddr_a, rf_raddr_b, rf_waddr;
    logic [DATA_W-1:0] rf_q_a, rf_q_b, rf_wdata;
    logic              rf_we;

    // data memory banks
    logic [ROW_W-1:0]  ev_raddr, od_raddr, ev_waddr, od_waddr;
    logic [7:0]        ev_q, od_q, ev_wdata, od_wdata;
    logic              mem_we;

    // datapath
    logic              r1_ok, r2_ok;
    logic [DATA_W-1:0] dst, r2v, src, mem_word;
    logic [ADDR_W-1:0] rd_p, wr_p;
    logic [ROW_W-1:0]  rd_row, wr_row;
    logic              rd_odd, wr_odd;
    logic [2*DATA_W-1:0] prod;

    // execute results
    logic              reg_we;
    logic [DATA_W-1:0] reg_wdata;
    logic              mem_wr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_waddr_w;
    logic [1:0]        flag_new;
    logic [DATA_W-1:0] step;
    logic              halt_v, ov_v, dz_v;
    logic [DATA_W-1:0] oval_v;
    logic [DATA_W-1:0] ip_new;

    // handshake and sequencing
    logic              accept, out_free, need_mem, div_needed, exec_go, finish;
    logic              clearing, div_start, div_done;
    logic [DATA_W-1:0] div_quo;

    assign accept   = in_valid && in_ready;
    assign out_free = !res_valid_reg || res_ready;
    assign clearing = (state_reg == ST_CLEAR);

    // ---------------------------------------------------------------
    // register file: read addresses come from the live request while
    // idle so the data is ready the cycle after acceptance
    // ---------------------------------------------------------------
    assign rf_raddr_a = (state_reg == ST_IDLE) ? dst_idx[REG_W-1:0] : r1_reg[REG_W-1:0];
    assign rf_raddr_b = (state_reg == ST_IDLE) ? src_idx[REG_W-1:0] : r2_reg[REG_W-1:0];

    assign r1_ok = ({1'b0, r1_reg} < REGIDX_W'(NUM_REGS));
    assign r2_ok = ({1'b0, r2_reg} < REGIDX_W'(NUM_REGS));
    assign dst   = r1_ok ? rf_q_a : '0;
    assign r2v   = r2_ok ? rf_q_b : '0;

    // the clearing pass also zeroes the registers on its first rows
    assign rf_we    = clearing ? (clr_reg < ROW_W'(NUM_REGS)) : (finish && reg_we && r1_ok);
    assign rf_waddr = clearing ? clr_reg[REG_W-1:0] : r1_reg[REG_W-1:0];
    assign rf_wdata = clearing ? '0 : reg_wdata;

    tcpu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr_a),
        .rdata (rf_q_a)
    );

    tcpu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr_b),
        .rdata (rf_q_b)
    );

    // ---------------------------------------------------------------
    // data memory: byte p sits in the even bank when p is even, so a
    // word at an odd address takes its low byte from the next even row
    // ---------------------------------------------------------------
    assign rd_p     = r2v[ADDR_W-1:0];
    assign rd_row   = rd_p[ADDR_W-1:1];
    assign rd_odd   = rd_p[0];
    assign ev_raddr = rd_row + {{(ROW_W-1){1'b0}}, rd_odd};
    assign od_raddr = rd_row;
    assign mem_word = rd_odd ? {od_q, ev_q} : {ev_q, od_q};

    assign wr_p     = mem_waddr_w[ADDR_W-1:0];
    assign wr_row   = wr_p[ADDR_W-1:1];
    assign wr_odd   = wr_p[0];

    assign mem_we   = clearing || (finish && mem_wr);
    assign ev_waddr = clearing ? clr_reg : (wr_row + {{(ROW_W-1){1'b0}}, wr_odd});
    assign od_waddr = clearing ? clr_reg : wr_row;
    assign ev_wdata = clearing ? 8'h00 : (wr_odd ? mem_wdata[7:0]  : mem_wdata[15:8]);
    assign od_wdata = clearing ? 8'h00 : (wr_odd ? mem_wdata[15:8] : mem_wdata[7:0]);

    tcpu_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_mem_even (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ev_waddr),
        .wdata (ev_wdata),
        .raddr (ev_raddr),
        .rdata (ev_q)
    );

    tcpu_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_mem_odd (
        .clk   (clk),
        .we    (mem_we),
        .waddr (od_waddr),
        .wdata (od_wdata),
        .raddr (od_raddr),
        .rdata (od_q)
    );

    // ---------------------------------------------------------------
    // operand selection
    // ---------------------------------------------------------------
    assign src  = (r2_reg == 4'd0) ? imm_reg : mem_word;
    assign prod = dst * src;

    // a memory read is needed only when the operand is used and comes from memory
    always_comb
    begin
        need_mem = 1'b0;
        if (r2_reg != 4'd0)
        begin
            case (op_reg)
                OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                OP_AND, OP_OR, OP_NOT, OP_CMP: need_mem = 1'b1;
                OP_MOV:                        need_mem = (r2_reg > MOV_STORE_MAX);
                default:                       need_mem = 1'b0;
            endcase
        end
    end

    assign div_needed = (op_reg == OP_DIV) && (src != '0);
    assign exec_go    = ((state_reg == ST_REG) && !need_mem) || (state_reg == ST_MEM);
    assign div_start  = exec_go && div_needed;
    assign finish     = out_free &&
                        ((exec_go && !div_needed) || ((state_reg == ST_DIV) && div_done));

    tcpu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dst),
        .divisor  (src),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------------------------------------------------------
    // execute: effects of the instruction, committed only on finish
    // ---------------------------------------------------------------
    always_comb
    begin
        reg_we      = 1'b0;
        reg_wdata   = dst;
        mem_wr      = 1'b0;
        mem_wdata   = r2v;
        mem_waddr_w = r2v;
        flag_new    = flag_reg;
        step        = IP_STEP;
        halt_v      = 1'b0;
        ov_v        = 1'b0;
        oval_v      = '0;
        dz_v        = 1'b0;
        case (op_reg)
            OP_HALT:
            begin
                halt_v = 1'b1;
            end
            OP_MOV:
            begin
                if (r2_reg == 4'd0)
                begin
                    reg_we    = 1'b1;
                    reg_wdata = imm_reg;
                end
                else if (r2_reg > MOV_STORE_MAX)
                begin
                    reg_we    = 1'b1;
                    reg_wdata = src;
                end
                else
                begin
                    // store register to the word addressed by the destination
                    mem_wr      = 1'b1;
                    mem_waddr_w = dst;
                    mem_wdata   = r2v;
                end
            end
            OP_ADD:
            begin
                reg_we    = 1'b1;
                reg_wdata = dst + src;
            end
            OP_SUB:
            begin
                reg_we    = 1'b1;
                reg_wdata = dst - src;
            end
            OP_MUL:
            begin
                reg_we    = 1'b1;
                reg_wdata = prod[DATA_W-1:0];
            end
            OP_DIV:
            begin
                // zero divisor leaves the register alone
                if (src == '0)
                begin
                    dz_v = 1'b1;
                end
                else
                begin
                    reg_we    = 1'b1;
                    reg_wdata = div_quo;
                end
            end
            OP_AND:
            begin
                reg_we    = 1'b1;
                reg_wdata = {{(DATA_W-1){1'b0}}, ((dst != '0) && (src != '0))};
            end
            OP_OR:
            begin
                reg_we    = 1'b1;
                reg_wdata = {{(DATA_W-1){1'b0}}, ((dst != '0) || (src != '0))};
            end
            OP_NOT:
            begin
                if (r2_reg == 4'd0)
                begin
                    reg_we    = 1'b1;
                    reg_wdata = {{(DATA_W-1){1'b0}}, (dst == '0)};
                end
                else
                begin
                    // logical inverse written back to the operand word
                    mem_wr      = 1'b1;
                    mem_waddr_w = r2v;
                    mem_wdata   = {{(DATA_W-1){1'b0}}, (src == '0)};
                end
            end
            OP_CMP:
            begin
                if (dst == src)
                begin
                    flag_new = FLAG_EQ;
                end
                else if ($signed(dst) > $signed(src))
                begin
                    flag_new = FLAG_GT;
                end
                else
                begin
                    flag_new = FLAG_LT;
                end
            end
            OP_JMP:
            begin
                case (r2_reg)
                    JC_ALWAYS: step = imm_reg;
                    JC_EQ:     step = (flag_reg == FLAG_EQ) ? imm_reg : IP_STEP;
                    JC_GT:     step = (flag_reg == FLAG_GT) ? imm_reg : IP_STEP;
                    JC_LT:     step = (flag_reg == FLAG_LT) ? imm_reg : IP_STEP;
                    default:   step = '0;
                endcase
            end
            OP_IN:
            begin
                reg_we    = 1'b1;
                reg_wdata = inv_reg;
            end
            OP_OUT:
            begin
                ov_v   = 1'b1;
                oval_v = dst;
            end
            default:
            begin
                // unused opcodes leave everything, ip included, untouched
                step = '0;
            end
        endcase
    end

    assign ip_new = ip_reg + step;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_REG;
                end
            end
            ST_REG:
            begin
                if (need_mem)
                begin
                    state_next = ST_MEM;
                end
                else if (div_needed)
                begin
                    state_next = ST_DIV;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEM:
            begin
                if (div_needed)
                begin
                    state_next = ST_DIV;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // latched request fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(cmd);
            r1_reg  <= dst_idx;
            r2_reg  <= src_idx;
            imm_reg <= imm;
            inv_reg <= in_value;
        end
    end

    // architectural ip and compare flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg   <= '0;
            flag_reg <= FLAG_EQ;
        end
        else if (finish)
        begin
            ip_reg   <= ip_new;
            flag_reg <= flag_new;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            next_ip_reg     <= ip_new;
            cmp_flag_reg    <= flag_new;
            halted_reg      <= halt_v;
            out_valid_reg   <= ov_v;
            out_value_reg   <= oval_v;
            div_by_zero_reg <= dz_v;
        end
    end

    assign res_valid   = res_valid_reg;
    assign next_ip     = next_ip_reg;
    assign cmp_flag    = cmp_flag_reg;
    assign halted      = halted_reg;
    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign div_by_zero = div_by_zero_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `TCPU_ASSERT_IMPL(a_clear_blocks_requests, state_reg == ST_CLEAR, !in_ready)
    `TCPU_ASSERT_NEXT(a_accept_starts_work, in_valid && in_ready, state_reg != ST_IDLE)
    `TCPU_ASSERT_IMPL(a_div_nonzero_divisor, div_start, src != '0)
    `TCPU_ASSERT_NEXT(a_finish_returns_idle, finish, res_valid && state_reg == ST_IDLE)

endmodule

// File: hw/rtl/tcpu_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module tcpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/tcpu_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on tcpu_pkg
module tcpu_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [tcpu_pkg::DATA_W-1:0] dividend,
    input  logic signed [tcpu_pkg::DATA_W-1:0] divisor,
    output logic                              done,
    output logic signed [tcpu_pkg::DATA_W-1:0] quotient
);
    import tcpu_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;
    logic              neg_reg;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] num_abs;
    logic [DATA_W-1:0] den_abs;

    assign num_abs = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
    assign den_abs = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
    assign rem_sh  = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DATA_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num_abs;
            den_reg <= den_abs;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            // restoring step: keep the difference when it did not go negative
            if (!diff[DATA_W])
            begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule
